@@ src/lkd_pkg.sv @@
// Shared package for the LRU key directory.
// Holds operation and status codes, fixed field widths and the entry command struct.
// No dependencies.
`default_nettype none

package lkd_pkg;

   localparam int KEY_W      = 64;
   localparam int TLEN_W     = 16;
   localparam int DSIZE_W    = 16;
   localparam int CAP_W      = 7;
   localparam int STATUS_W   = 3;
   localparam int REQ_DATA_W = 104;

   localparam logic OP_REMEMBER = 1'b0;
   localparam logic OP_LOOKUP   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_REJECT = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UPDATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EVICT  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_HIT    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MISS   = 3'd5;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Broadcast to every entry cell when an item changes the directory.
   typedef struct packed {
      logic promote;       // existing entry moves to the front
      logic claim;         // new key takes the selected slot
      logic write_length;  // selected entry stores the new length
   } cell_cmd_type;

endpackage

`default_nettype wire

@@ src/lru_key_directory_unit.sv @@
// An accepted item is held in the input register and its result is registered in the result register.
// Throughput: one item per cycle while results are taken; all entries compare their keys in parallel in that cycle.
// The input register takes a new item whenever the result register is free or being taken.
// Reset clears all valid marks and the entry count at once (no clearing pass) and
// sets the capacity register to 64; keys, lengths and ranks need no reset.
// Top level of the LRU key directory; depends on lkd_pkg and lkd_entry.
`default_nettype none

module lru_key_directory_unit #(
   parameter int  DEPTH        = 64,
   parameter int  MAX_TEXT_LEN = 2048,
   localparam int SLOT_W       = $clog2(DEPTH),
   localparam int LEN_W        = $clog2(MAX_TEXT_LEN),
   localparam int RSP_RAW_W    = SLOT_W + LEN_W + lkd_pkg::KEY_W,
   localparam int RSP_DATA_W   = ((RSP_RAW_W + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [lkd_pkg::CAP_W-1:0]         csr_wdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // query_key, text_present, text_length, dest_size
   input  wire logic [lkd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // slot, length_out, evicted_key
   output logic [RSP_DATA_W-1:0]                  rsp_tdata,
   // status
   output logic [lkd_pkg::STATUS_W-1:0]           rsp_tuser
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EW    = CNT_W + lkd_pkg::CAP_W;
   localparam int LW    = lkd_pkg::TLEN_W + 1;

   // Capacity register.
   logic [lkd_pkg::CAP_W-1:0] capacity_ff;

   // Input register.
   logic                           in_valid_ff;
   logic                           op_ff;
   logic [lkd_pkg::KEY_W-1:0]      key_ff;
   logic                           present_ff;
   logic [lkd_pkg::TLEN_W-1:0]     tlen_ff;
   logic [lkd_pkg::DSIZE_W-1:0]    dsize_ff;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lkd_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_W-1:0]              slot_ff, slot_in;
   logic [LEN_W-1:0]               len_ff, len_in;
   logic [lkd_pkg::KEY_W-1:0]      evict_ff, evict_in;

   logic [CNT_W-1:0]               count_ff, count_in;

   logic                           res_take;
   logic [DEPTH-1:0]               valid_vec, match_vec, inv_vec, free_vec, target_vec;
   logic [lkd_pkg::KEY_W-1:0]      key_lru   [DEPTH];
   logic [LEN_W-1:0]               len_hit   [DEPTH];
   logic [SLOT_W-1:0]              rank_hit  [DEPTH];
   logic [lkd_pkg::KEY_W-1:0]      oldest_key;
   logic [LEN_W-1:0]               hit_len;
   logic [SLOT_W-1:0]              hit_rank;
   logic [SLOT_W-1:0]              target_idx;
   logic [SLOT_W-1:0]              last_rank;
   logic [EW-1:0]                  eff_cap;
   logic                           key_ok, rem_ok, look_ok, hit_any, full, update;
   logic [LEN_W-1:0]               stored_len;
   logic [lkd_pkg::DSIZE_W-1:0]    dsize_m1;
   lkd_pkg::cell_cmd_type          cmd;

   assign res_take   = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || res_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lkd_pkg::CAP_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff      <= req_tuser;
         key_ff     <= req_tdata[63:0];
         present_ff <= req_tdata[64];
         tlen_ff    <= req_tdata[80:65];
         dsize_ff   <= req_tdata[96:81];
      end
      if (res_take) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         len_ff    <= len_in;
         evict_ff  <= evict_in;
      end
   end

   // Entry cells.
   assign last_rank = SLOT_W'(count_ff - 1'b1);

   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      lkd_entry #(
         .RANK_W (SLOT_W),
         .LEN_W  (LEN_W)
      ) u_entry (
         .clock     (clock),
         .reset     (reset),
         .update    (update),
         .cmd       (cmd),
         .sel       (target_vec[g]),
         .query_key (key_ff),
         .length_in (stored_len),
         .limit     (hit_rank),
         .last_rank (last_rank),
         .valid     (valid_vec[g]),
         .match     (match_vec[g]),
         .key_lru   (key_lru[g]),
         .len_hit   (len_hit[g]),
         .rank_hit  (rank_hit[g])
      );
   end

   // Masked entry outputs are zero except at the selected entry, so OR-ing selects.
   always_comb begin
      oldest_key = '0;
      hit_len    = '0;
      hit_rank   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         oldest_key = oldest_key | key_lru[i];
         hit_len    = hit_len | len_hit[i];
         hit_rank   = hit_rank | rank_hit[i];
      end
   end

   // Lowest-indexed free slot as a one-hot vector.
   assign inv_vec  = ~valid_vec;
   assign free_vec = inv_vec & (~inv_vec + {{(DEPTH-1){1'b0}}, 1'b1});

   always_comb begin
      if (capacity_ff == '0 || EW'(capacity_ff) > EW'(DEPTH)) begin
         eff_cap = EW'(DEPTH);
      end else begin
         eff_cap = EW'(capacity_ff);
      end
   end

   assign key_ok  = key_ff != '0;
   assign rem_ok  = (op_ff == lkd_pkg::OP_REMEMBER) && key_ok && present_ff;
   assign look_ok = (op_ff == lkd_pkg::OP_LOOKUP) && key_ok && (dsize_ff != '0);
   assign hit_any = |match_vec;
   assign full    = EW'(count_ff) >= eff_cap;
   assign dsize_m1 = dsize_ff - 1'b1;

   always_comb begin
      if (LW'(tlen_ff) >= LW'(MAX_TEXT_LEN)) begin
         stored_len = LEN_W'(MAX_TEXT_LEN - 1);
      end else begin
         stored_len = tlen_ff[LEN_W-1:0];
      end
   end

   // The LRU entry is the valid one holding the highest rank, count minus one.
   // Stored keys are never zero, so its masked key being nonzero marks it.
   always_comb begin
      if (hit_any) begin
         target_vec = match_vec;
      end else if (full) begin
         for (int i = 0; i < DEPTH; i++) begin
            target_vec[i] = key_lru[i] != '0;
         end
      end else begin
         target_vec = free_vec;
      end
   end

   always_comb begin
      target_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (target_vec[i]) begin
            target_idx = target_idx | SLOT_W'(i);
         end
      end
   end

   assign update = res_take && (rem_ok || (look_ok && hit_any));

   always_comb begin
      cmd.promote      = hit_any;
      cmd.claim        = rem_ok && !hit_any;
      cmd.write_length = rem_ok;
   end

   always_comb begin
      count_in = count_ff;
      if (update && cmd.claim && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      status_in = lkd_pkg::ST_REJECT;
      slot_in   = '0;
      len_in    = '0;
      evict_in  = '0;
      if (rem_ok) begin
         slot_in = target_idx;
         len_in  = stored_len;
         if (hit_any) begin
            status_in = lkd_pkg::ST_UPDATE;
         end else if (full) begin
            status_in = lkd_pkg::ST_EVICT;
            evict_in  = oldest_key;
         end else begin
            status_in = lkd_pkg::ST_INSERT;
         end
      end else if (look_ok) begin
         if (hit_any) begin
            status_in = lkd_pkg::ST_HIT;
            slot_in   = target_idx;
            if (lkd_pkg::DSIZE_W'(hit_len) > dsize_m1) begin
               len_in = dsize_m1[LEN_W-1:0];
            end else begin
               len_in = hit_len;
            end
         end else begin
            status_in = lkd_pkg::ST_MISS;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_DATA_W'({evict_ff, len_ff, slot_ff});

endmodule

`default_nettype wire

@@ src/lkd_entry.sv @@
// One directory entry: key, length, recency rank and valid mark.
// Compares its key against the query and updates its rank on every directory change.
// Depends on lkd_pkg.
`default_nettype none

module lkd_entry #(
   parameter int RANK_W = 6,
   parameter int LEN_W  = 11
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     update,
   input  wire lkd_pkg::cell_cmd_type    cmd,
   input  wire logic                     sel,
   input  wire logic [lkd_pkg::KEY_W-1:0] query_key,
   input  wire logic [LEN_W-1:0]         length_in,
   input  wire logic [RANK_W-1:0]        limit,
   input  wire logic [RANK_W-1:0]        last_rank,
   output logic                          valid,
   output logic                          match,
   output logic [lkd_pkg::KEY_W-1:0]     key_lru,
   output logic [LEN_W-1:0]              len_hit,
   output logic [RANK_W-1:0]             rank_hit
);

   logic                      valid_ff, valid_in;
   logic [lkd_pkg::KEY_W-1:0] key_ff, key_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [RANK_W-1:0]         rank_ff, rank_in;
   logic                      is_lru;

   assign valid    = valid_ff;
   assign match    = valid_ff && (key_ff == query_key);
   assign is_lru   = valid_ff && (rank_ff == last_rank);
   assign key_lru  = is_lru ? key_ff : '0;
   assign len_hit  = match ? len_ff : '0;
   assign rank_hit = match ? rank_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      len_in   = len_ff;
      rank_in  = rank_ff;
      if (update) begin
         if (sel) begin
            rank_in = '0;
            if (cmd.write_length) begin
               len_in = length_in;
            end
            if (cmd.claim) begin
               valid_in = 1'b1;
               key_in   = query_key;
            end
         end else if (valid_ff) begin
            // A new key pushes every other entry back; a promotion only those ahead of it.
            if (cmd.claim || (cmd.promote && (rank_ff < limit))) begin
               rank_in = rank_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      len_ff  <= len_in;
      rank_ff <= rank_in;
   end

endmodule

`default_nettype wire
